// ----- design/ffca_pkg.sv -----
// Shared constants and types for the first-fit cell allocator.
`timescale 1ns / 1ps

package ffca_pkg;

   // Default pool geometry.
   localparam int CELLS_DEF   = 1024;
   localparam int GRANULE_DEF = 64;

   // Fixed field widths of the item and result ports.
   localparam int SIZE_W   = 11;
   localparam int START_W  = 10;
   localparam int STATUS_W = 2;

   typedef logic [STATUS_W-1:0] status_type;

   // Request modes.
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Result status codes.
   localparam status_type ST_DONE     = 2'd0;
   localparam status_type ST_NOSPACE  = 2'd1;
   localparam status_type ST_NOTALLOC = 2'd2;

endpackage

// ----- design/first_fit_cell_allocator_unit.sv -----
// Top level of the first-fit cell allocator: sequencer, scan unit and the two stores.
//
//  channel   ports                                        handshake
//  request   req_mode, req_size, req_start_cell           taken when start && !busy
//  result    rsp_status, rsp_granted_start,               rsp_valid, one cycle,
//            rsp_free_cells, rsp_longest_run,             cannot be held off
//            rsp_released_size
//
// One scan unit walks the occupancy RAM one cell per cycle. An allocate runs a statistics
// pass, a first-fit pass and the marking of the run; a refused allocate ends after the
// first pass. A free clears the released run one cell at a time, bounded by the single
// write port of the occupancy RAM.
// After reset a clearing pass wipes both stores while busy is high.
// busy is high from the item's acceptance until its result strobe; the receiver never stalls.
`timescale 1ns / 1ps

module first_fit_cell_allocator_unit #(
   parameter int CELLS   = ffca_pkg::CELLS_DEF,
   parameter int GRANULE = ffca_pkg::GRANULE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_mode,
   input  logic [ffca_pkg::SIZE_W-1:0]    req_size,
   input  logic [ffca_pkg::START_W-1:0]   req_start_cell,
   output logic                           rsp_valid,
   output ffca_pkg::status_type           rsp_status,
   output logic [ffca_pkg::START_W-1:0]   rsp_granted_start,
   output logic [ffca_pkg::SIZE_W-1:0]    rsp_free_cells,
   output logic [ffca_pkg::SIZE_W-1:0]    rsp_longest_run,
   output logic [ffca_pkg::SIZE_W-1:0]    rsp_released_size
);

   import ffca_pkg::*;

   localparam int CW = $clog2(CELLS);
   localparam int NW = $clog2(CELLS + 1);
   localparam int GW = $clog2(GRANULE + 1);
   localparam int XW = NW + SIZE_W;

   // Sequencer states.
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_STAT  = 3'd2;
   localparam logic [2:0] S_FIT   = 3'd3;
   localparam logic [2:0] S_MARK  = 3'd4;
   localparam logic [2:0] S_FRD   = 3'd5;
   localparam logic [2:0] S_FCHK  = 3'd6;
   localparam logic [2:0] S_FCLR  = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [NW-1:0]       ia_ff, ia_in;
   logic                dv_ff, dv_in;
   logic [CW-1:0]       pa_ff, pa_in;
   logic [NW-1:0]       run_ff, run_in;
   logic [NW-1:0]       best_ff, best_in;
   logic [NW-1:0]       free_ff, free_in;
   logic [GW-1:0]       sub_ff, sub_in;
   logic [NW-1:0]       grun_ff, grun_in;
   logic [NW-1:0]       gbest_ff, gbest_in;
   logic [NW-1:0]       w_ff, w_in;
   logic [SIZE_W-1:0]   rem_ff, rem_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [SIZE_W-1:0]   rel_ff, rel_in;
   logic [CW-1:0]       start_ff, start_in;
   logic                start_ok_ff, start_ok_in;
   logic [CW-1:0]       grant_ff, grant_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]  rsp_granted_ff, rsp_granted_in;
   logic [SIZE_W-1:0]   rsp_free_ff, rsp_free_in;
   logic [SIZE_W-1:0]   rsp_longest_ff, rsp_longest_in;
   logic [SIZE_W-1:0]   rsp_released_ff, rsp_released_in;

   logic                occ_we;
   logic [CW-1:0]       occ_waddr;
   logic [0:0]          occ_wdata;
   logic [0:0]          occ_rd;
   logic                tbl_we;
   logic [CW-1:0]       tbl_waddr;
   logic [SIZE_W-1:0]   tbl_wdata;
   logic [SIZE_W-1:0]   tbl_rd;

   logic                issuing;
   logic                scan_end;
   logic                fit_hit;
   logic                refuse;
   logic [NW-1:0]       run_inc;
   logic [NW-1:0]       grun_add;
   logic [XW-1:0]       size_x;
   logic [XW-1:0]       run_x;
   logic [XW-1:0]       gbest_x;
   logic [XW-1:0]       grant_x;
   logic [XW-1:0]       start_x;
   logic [XW-1:0]       grant_out_x;
   logic [XW-1:0]       free_x;
   logic [XW-1:0]       best_x;

   // Occupancy map, one bit per cell.
   ffca_ram #(.WIDTH(1), .DEPTH(CELLS)) u_occ_ram (
      .clock   (clock),
      .wr_en   (occ_we),
      .wr_addr (occ_waddr),
      .wr_data (occ_wdata),
      .rd_addr (ia_ff[CW-1:0]),
      .rd_data (occ_rd)
   );

   // Run size table, indexed by the start cell of each run.
   ffca_ram #(.WIDTH(SIZE_W), .DEPTH(CELLS)) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (start_ff),
      .rd_data (tbl_rd)
   );

   // Scan unit terms: the incrementers and compares on the runs in progress.
   assign issuing     = ((state_ff == S_STAT) || (state_ff == S_FIT)) &&
                        (ia_ff != NW'(CELLS));
   assign scan_end    = !issuing && !dv_ff;
   assign run_inc     = run_ff + NW'(1);
   assign grun_add    = grun_ff + NW'(GRANULE);
   assign size_x      = XW'(size_ff);
   assign run_x       = XW'(run_inc);
   assign gbest_x     = XW'(gbest_ff);
   assign grant_x     = XW'(pa_ff) + XW'(1) - size_x;
   assign start_x     = XW'(req_start_cell);
   assign grant_out_x = XW'(grant_ff);
   assign free_x      = XW'(free_ff);
   assign best_x      = XW'(best_ff);
   assign fit_hit     = (state_ff == S_FIT) && dv_ff && !occ_rd[0] && (run_x == size_x);
   // The largest whole-granule part of any free run must cover the request.
   assign refuse      = (size_ff == '0) || (size_x > XW'(CELLS)) || (gbest_x < size_x);

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in        = state_ff;
      ia_in           = ia_ff;
      dv_in           = 1'b0;
      pa_in           = pa_ff;
      run_in          = run_ff;
      best_in         = best_ff;
      free_in         = free_ff;
      sub_in          = sub_ff;
      grun_in         = grun_ff;
      gbest_in        = gbest_ff;
      w_in            = w_ff;
      rem_in          = rem_ff;
      size_in         = size_ff;
      rel_in          = rel_ff;
      start_in        = start_ff;
      start_ok_in     = start_ok_ff;
      grant_in        = grant_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_granted_in  = rsp_granted_ff;
      rsp_free_in     = rsp_free_ff;
      rsp_longest_in  = rsp_longest_ff;
      rsp_released_in = rsp_released_ff;
      occ_we          = 1'b0;
      occ_waddr       = w_ff[CW-1:0];
      occ_wdata       = 1'b0;
      tbl_we          = 1'b0;
      tbl_waddr       = w_ff[CW-1:0];
      tbl_wdata       = '0;

      // Read issue for both scan passes: one cell address per cycle.
      if (issuing) begin
         ia_in = ia_ff + NW'(1);
         pa_in = ia_ff[CW-1:0];
         dv_in = 1'b1;
      end

      unique case (state_ff)
         S_CLEAR: begin
            occ_we = 1'b1;
            tbl_we = 1'b1;
            w_in   = w_ff + NW'(1);
            if (w_ff == NW'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               size_in     = req_size;
               start_in    = start_x[CW-1:0];
               start_ok_in = start_x < XW'(CELLS);
               ia_in       = '0;
               run_in      = '0;
               best_in     = '0;
               free_in     = '0;
               sub_in      = '0;
               grun_in     = '0;
               gbest_in    = '0;
               state_in    = (req_mode == MODE_FREE) ? S_FRD : S_STAT;
            end
         end
         S_STAT: begin
            // Count free cells, the longest run and its whole-granule part.
            if (dv_ff) begin
               if (!occ_rd[0]) begin
                  free_in = free_ff + NW'(1);
                  run_in  = run_inc;
                  if (run_inc > best_ff) begin
                     best_in = run_inc;
                  end
                  if (sub_ff == GW'(GRANULE - 1)) begin
                     sub_in  = '0;
                     grun_in = grun_add;
                     if (grun_add > gbest_ff) begin
                        gbest_in = grun_add;
                     end
                  end else begin
                     sub_in = sub_ff + GW'(1);
                  end
               end else begin
                  run_in  = '0;
                  sub_in  = '0;
                  grun_in = '0;
               end
            end
            if (scan_end) begin
               if (refuse) begin
                  state_in        = S_IDLE;
                  rsp_valid_in    = 1'b1;
                  rsp_status_in   = ST_NOSPACE;
                  rsp_granted_in  = '0;
                  rsp_free_in     = free_x[SIZE_W-1:0];
                  rsp_longest_in  = best_x[SIZE_W-1:0];
                  rsp_released_in = '0;
               end else begin
                  state_in = S_FIT;
                  ia_in    = '0;
                  run_in   = '0;
               end
            end
         end
         S_FIT: begin
            // First free run that reaches the requested size.
            if (dv_ff) begin
               run_in = occ_rd[0] ? '0 : run_inc;
            end
            if (fit_hit) begin
               grant_in  = grant_x[CW-1:0];
               w_in      = grant_x[NW-1:0];
               rem_in    = size_ff;
               tbl_we    = 1'b1;
               tbl_waddr = grant_x[CW-1:0];
               tbl_wdata = size_ff;
               dv_in     = 1'b0;
               state_in  = S_MARK;
            end else if (scan_end) begin
               state_in        = S_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_NOSPACE;
               rsp_granted_in  = '0;
               rsp_free_in     = free_x[SIZE_W-1:0];
               rsp_longest_in  = best_x[SIZE_W-1:0];
               rsp_released_in = '0;
            end
         end
         S_MARK: begin
            occ_we    = 1'b1;
            occ_wdata = 1'b1;
            w_in      = w_ff + NW'(1);
            rem_in    = rem_ff - SIZE_W'(1);
            if (rem_ff == SIZE_W'(1)) begin
               state_in        = S_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_DONE;
               rsp_granted_in  = grant_out_x[START_W-1:0];
               rsp_free_in     = free_x[SIZE_W-1:0];
               rsp_longest_in  = best_x[SIZE_W-1:0];
               rsp_released_in = '0;
            end
         end
         S_FRD: begin
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (!start_ok_ff || (tbl_rd == '0)) begin
               state_in        = S_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_NOTALLOC;
               rsp_granted_in  = '0;
               rsp_free_in     = '0;
               rsp_longest_in  = '0;
               rsp_released_in = '0;
            end else begin
               tbl_we    = 1'b1;
               tbl_waddr = start_ff;
               rem_in    = tbl_rd;
               rel_in    = tbl_rd;
               w_in      = NW'(start_ff);
               state_in  = S_FCLR;
            end
         end
         S_FCLR: begin
            // Clear the recorded run, never past the last cell.
            if ((rem_ff != '0) && (w_ff != NW'(CELLS))) begin
               occ_we = 1'b1;
               w_in   = w_ff + NW'(1);
               rem_in = rem_ff - SIZE_W'(1);
            end else begin
               state_in        = S_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_DONE;
               rsp_granted_in  = '0;
               rsp_free_in     = '0;
               rsp_longest_in  = '0;
               rsp_released_in = rel_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         w_ff         <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and result registers.
   always_ff @(posedge clock) begin
      ia_ff           <= ia_in;
      pa_ff           <= pa_in;
      run_ff          <= run_in;
      best_ff         <= best_in;
      free_ff         <= free_in;
      sub_ff          <= sub_in;
      grun_ff         <= grun_in;
      gbest_ff        <= gbest_in;
      rem_ff          <= rem_in;
      size_ff         <= size_in;
      rel_ff          <= rel_in;
      start_ff        <= start_in;
      start_ok_ff     <= start_ok_in;
      grant_ff        <= grant_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_granted_ff  <= rsp_granted_in;
      rsp_free_ff     <= rsp_free_in;
      rsp_longest_ff  <= rsp_longest_in;
      rsp_released_ff <= rsp_released_in;
   end

   assign busy              = state_ff != S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_start = rsp_granted_ff;
   assign rsp_free_cells    = rsp_free_ff;
   assign rsp_longest_run   = rsp_longest_ff;
   assign rsp_released_size = rsp_released_ff;

`ifndef SYNTHESIS
   // A result strobe never lasts more than one cycle.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held for two cycles");

   // An accepted item makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not raise busy");

   // The occupancy map is only written while an item or the clearing pass runs.
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      occ_we |-> busy) else $error("occupancy write while idle");

   // A refused allocate grants and releases nothing.
   a_refuse_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_NOSPACE)) |->
         ((rsp_granted_start == '0) && (rsp_released_size == '0)))
      else $error("refused allocate carries a grant");

   // Marking always has at least one cell left to write.
   a_mark_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> (rem_ff != '0)) else $error("marking with no cells left");
`endif

endmodule

// ----- design/ffca_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ffca_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
